>>> rtl/osmrd_pkg.sv
// shared types, constants and codes for the option set mixed-radix decoder
// used by every module of the block, no dependencies
package osmrd_pkg;

    localparam int IN_INDEX_W   = 48;
    localparam int COUNT_W      = 49;
    localparam int TOGGLE_REG_W = 16;
    localparam int SELECT_REG_W = 8;
    localparam int SEL_IDX_W    = $clog2(SELECT_REG_W);
    localparam int CHOICE_W     = 4;
    localparam int RADIX_W      = CHOICE_W + 1;
    localparam int SLOT_W       = 4;
    localparam int KIND_W       = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 3;

    localparam int DEF_MAX_TOGGLES = 16;
    localparam int DEF_MAX_SELECTS = 8;
    localparam int DEF_INDEX_WIDTH = 48;

    localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SELECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINAL  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOGGLE_VERTEX = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOGGLE_PIXEL  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SELECT_VERTEX = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SELECT_PIXEL  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHOICE_COUNTS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPTIONAL      = 3'd5;

    typedef struct packed {
        logic                  shader_type;
        logic [IN_INDEX_W-1:0] option_index;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]   item_kind;
        logic [SLOT_W-1:0]   slot;
        logic [CHOICE_W-1:0] choice;
        logic [COUNT_W-1:0]  set_count;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic shift;
        logic start;
        logic step;
    } t_div_ctrl;

    typedef struct packed {
        logic init;
        logic dbl;
        logic clear;
        logic start;
        logic step;
    } t_cnt_ctrl;

endpackage

>>> rtl/osmrd_divider.sv
// bit-serial restoring divider holding the remaining permutation index
// divides by a small radix one quotient bit per cycle while i_ctrl.step is high; uses osmrd_pkg
module osmrd_divider #(
    parameter int INDEX_WIDTH = osmrd_pkg::DEF_INDEX_WIDTH
) (
    input  logic                              i_clk,
    input  osmrd_pkg::t_div_ctrl              i_ctrl,
    input  logic [INDEX_WIDTH-1:0]            i_load_value,
    input  logic [osmrd_pkg::RADIX_W-1:0]     i_radix,
    output logic                              o_idx_lsb,
    output logic [osmrd_pkg::CHOICE_W-1:0]    o_digit
);

    logic [INDEX_WIDTH-1:0]           r_idx;
    logic [osmrd_pkg::CHOICE_W-1:0]   r_rem;
    logic [osmrd_pkg::RADIX_W-1:0]    trial;
    logic [osmrd_pkg::RADIX_W-1:0]    diff;
    logic                             fits;

    always_comb begin
        trial = {r_rem, r_idx[INDEX_WIDTH-1]};
        diff  = trial - i_radix;
        fits  = (trial >= i_radix);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_idx <= i_load_value;
        end else if (i_ctrl.shift) begin
            r_idx <= {1'b0, r_idx[INDEX_WIDTH-1:1]};
        end else if (i_ctrl.step) begin
            r_idx <= {r_idx[INDEX_WIDTH-2:0], fits};
        end
        if (i_ctrl.start) begin
            r_rem <= '0;
        end else if (i_ctrl.step) begin
            r_rem <= fits ? diff[osmrd_pkg::CHOICE_W-1:0] : trial[osmrd_pkg::CHOICE_W-1:0];
        end
    end

    assign o_idx_lsb = r_idx[0];
    assign o_digit   = r_rem;

endmodule

>>> rtl/osmrd_count.sv
// permutation count register with a bit-serial multiply by a small radix
// rotates the count lsb first through a narrow adder; uses osmrd_pkg
module osmrd_count (
    input  logic                              i_clk,
    input  osmrd_pkg::t_cnt_ctrl              i_ctrl,
    input  logic [osmrd_pkg::RADIX_W-1:0]     i_radix,
    output logic [osmrd_pkg::COUNT_W-1:0]     o_count
);

    logic [osmrd_pkg::COUNT_W-1:0]    r_cnt;
    logic [osmrd_pkg::CHOICE_W-1:0]   r_carry;
    logic [osmrd_pkg::RADIX_W-1:0]    sum;

    always_comb begin
        sum = (r_cnt[0] ? i_radix : '0) + {1'b0, r_carry};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            r_cnt <= osmrd_pkg::COUNT_W'(1);
        end else if (i_ctrl.clear) begin
            r_cnt <= '0;
        end else if (i_ctrl.dbl) begin
            r_cnt <= {r_cnt[osmrd_pkg::COUNT_W-2:0], 1'b0};
        end else if (i_ctrl.step) begin
            r_cnt <= {sum[0], r_cnt[osmrd_pkg::COUNT_W-1:1]};
        end
        if (i_ctrl.start) begin
            r_carry <= '0;
        end else if (i_ctrl.step) begin
            r_carry <= sum[osmrd_pkg::RADIX_W-1:1];
        end
    end

    assign o_count = r_cnt;

endmodule

>>> rtl/option_set_mixed_radix_decode.sv
// top level of the option set mixed-radix decoder: registers, sequencer, output stage
// instantiates osmrd_divider and osmrd_count; uses osmrd_pkg
//
// usage
//   configuration: i_cfg_we writes i_cfg_data into register i_cfg_index; the user writes
//   only while idle, which the block does not enforce; indexes beyond the six registers are ignored
//   input: an item (shader type, permutation index) is taken when i_in_valid is high
//   and o_in_stall is low; o_in_stall stays high until the item's last result is queued
//   output: zero or more toggle items, zero or more select items, then one final item
//   with the permutation count and last set; taken when o_out_valid and !i_out_stall
//   timing: toggle slots are walked in the toggle state and select slots in the scan state;
//   a select slot that applies with a nonzero radix adds a serial pass of divider and
//   count multiplier over the count width and an emit step, and the final item ends the run
//   a stalled receiver holds the output register, and the sequencer waits at the next
//   item to emit; the next input item is taken once the final item is queued
//   reset clears the configuration registers, the sequencer and the output valid
module option_set_mixed_radix_decode #(
    parameter int MAX_TOGGLES = osmrd_pkg::DEF_MAX_TOGGLES,
    parameter int MAX_SELECTS = osmrd_pkg::DEF_MAX_SELECTS,
    parameter int INDEX_WIDTH = osmrd_pkg::DEF_INDEX_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [osmrd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [osmrd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  osmrd_pkg::t_in_item                  i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output osmrd_pkg::t_out_item                 o_out_item
);

    localparam int TL = (MAX_TOGGLES < osmrd_pkg::TOGGLE_REG_W) ? MAX_TOGGLES
                                                                : osmrd_pkg::TOGGLE_REG_W;
    localparam int SL = (MAX_SELECTS < osmrd_pkg::SELECT_REG_W) ? MAX_SELECTS
                                                                : osmrd_pkg::SELECT_REG_W;
    localparam int IW = (INDEX_WIDTH < osmrd_pkg::IN_INDEX_W) ? INDEX_WIDTH
                                                              : osmrd_pkg::IN_INDEX_W;
    localparam int STEP_W = $clog2(osmrd_pkg::COUNT_W);
    localparam logic [osmrd_pkg::SLOT_W-1:0] TL_LAST   = osmrd_pkg::SLOT_W'(TL - 1);
    localparam logic [osmrd_pkg::SLOT_W-1:0] SL_LAST   = osmrd_pkg::SLOT_W'(SL - 1);
    localparam logic [STEP_W-1:0]            STEP_LAST = STEP_W'(osmrd_pkg::COUNT_W - 1);
    localparam logic [STEP_W-1:0]            DIV_STEPS = STEP_W'(IW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOGGLE,
        ST_SCAN,
        ST_DIV,
        ST_EMIT,
        ST_FINAL
    } t_state;

    t_state                                 r_state;
    logic [osmrd_pkg::TOGGLE_REG_W-1:0]     r_tog_vtx;
    logic [osmrd_pkg::TOGGLE_REG_W-1:0]     r_tog_pix;
    logic [osmrd_pkg::SELECT_REG_W-1:0]     r_sel_vtx;
    logic [osmrd_pkg::SELECT_REG_W-1:0]     r_sel_pix;
    logic [osmrd_pkg::CFG_DATA_W-1:0]       r_sel_counts;
    logic [osmrd_pkg::SELECT_REG_W-1:0]     r_sel_opt;
    logic                                   r_pixel;
    logic [osmrd_pkg::SLOT_W-1:0]           r_slot;
    logic [STEP_W-1:0]                      r_step;
    logic [osmrd_pkg::RADIX_W-1:0]          r_radix;
    logic [osmrd_pkg::CHOICE_W-1:0]         r_choices;
    logic                                   r_opt;
    logic                                   r_out_valid;
    osmrd_pkg::t_out_item                   r_out;

    osmrd_pkg::t_div_ctrl                   div_ctrl;
    osmrd_pkg::t_cnt_ctrl                   cnt_ctrl;
    logic                                   idx_lsb;
    logic [osmrd_pkg::CHOICE_W-1:0]         digit;
    logic [osmrd_pkg::COUNT_W-1:0]          count;
    logic [osmrd_pkg::SEL_IDX_W-1:0]        sel_idx;
    logic [osmrd_pkg::TOGGLE_REG_W-1:0]     tmask;
    logic [osmrd_pkg::SELECT_REG_W-1:0]     smask;
    logic                                   tog_applies;
    logic                                   sel_applies;
    logic [osmrd_pkg::CHOICE_W-1:0]         choices;
    logic                                   opt;
    logic [osmrd_pkg::RADIX_W-1:0]          radix;
    logic                                   out_free;
    logic                                   in_accept;
    logic                                   emit_pair;
    logic                                   out_load;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tog_vtx    <= '0;
            r_tog_pix    <= '0;
            r_sel_vtx    <= '0;
            r_sel_pix    <= '0;
            r_sel_counts <= '0;
            r_sel_opt    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                osmrd_pkg::CFG_TOGGLE_VERTEX: begin
                    r_tog_vtx <= i_cfg_data[osmrd_pkg::TOGGLE_REG_W-1:0];
                end
                osmrd_pkg::CFG_TOGGLE_PIXEL: begin
                    r_tog_pix <= i_cfg_data[osmrd_pkg::TOGGLE_REG_W-1:0];
                end
                osmrd_pkg::CFG_SELECT_VERTEX: begin
                    r_sel_vtx <= i_cfg_data[osmrd_pkg::SELECT_REG_W-1:0];
                end
                osmrd_pkg::CFG_SELECT_PIXEL: begin
                    r_sel_pix <= i_cfg_data[osmrd_pkg::SELECT_REG_W-1:0];
                end
                osmrd_pkg::CFG_CHOICE_COUNTS: begin
                    r_sel_counts <= i_cfg_data;
                end
                osmrd_pkg::CFG_OPTIONAL: begin
                    r_sel_opt <= i_cfg_data[osmrd_pkg::SELECT_REG_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        sel_idx     = r_slot[osmrd_pkg::SEL_IDX_W-1:0];
        tmask       = r_pixel ? r_tog_pix : r_tog_vtx;
        smask       = r_pixel ? r_sel_pix : r_sel_vtx;
        tog_applies = tmask[r_slot];
        sel_applies = smask[sel_idx];
        choices     = r_sel_counts[{sel_idx, 2'b00} +: osmrd_pkg::CHOICE_W];
        opt         = r_sel_opt[sel_idx];
        radix       = {1'b0, choices} + {{osmrd_pkg::CHOICE_W{1'b0}}, opt};
        out_free    = !r_out_valid || !i_out_stall;
        in_accept   = i_in_valid && (r_state == ST_IDLE);
        emit_pair   = !r_opt || (digit != r_choices);
        out_load    = ((r_state == ST_TOGGLE) && tog_applies && idx_lsb && out_free)
                   || ((r_state == ST_EMIT) && emit_pair && out_free)
                   || ((r_state == ST_FINAL) && out_free);

        div_ctrl       = '0;
        cnt_ctrl       = '0;
        div_ctrl.load  = in_accept;
        cnt_ctrl.init  = in_accept;
        unique case (r_state)
            ST_TOGGLE: begin
                if (tog_applies && (!idx_lsb || out_free)) begin
                    div_ctrl.shift = 1'b1;
                    cnt_ctrl.dbl   = 1'b1;
                end
            end
            ST_SCAN: begin
                if (sel_applies) begin
                    if (radix == '0) begin
                        cnt_ctrl.clear = 1'b1;
                    end else begin
                        div_ctrl.start = 1'b1;
                        cnt_ctrl.start = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                cnt_ctrl.step = 1'b1;
                div_ctrl.step = (r_step < DIV_STEPS);
            end
            default: ;
        endcase
    end

    osmrd_divider #(
        .INDEX_WIDTH (IW)
    ) u_divider (
        .i_clk        (i_clk),
        .i_ctrl       (div_ctrl),
        .i_load_value (i_in_item.option_index[IW-1:0]),
        .i_radix      (r_radix),
        .o_idx_lsb    (idx_lsb),
        .o_digit      (digit)
    );

    osmrd_count u_count (
        .i_clk   (i_clk),
        .i_ctrl  (cnt_ctrl),
        .i_radix (r_radix),
        .o_count (count)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_pixel <= i_in_item.shader_type;
                        r_slot  <= '0;
                        r_state <= ST_TOGGLE;
                    end
                end
                ST_TOGGLE: begin
                    if (!tog_applies || !idx_lsb || out_free) begin
                        if (tog_applies && idx_lsb) begin
                            r_out_valid         <= 1'b1;
                            r_out.item_kind     <= osmrd_pkg::KIND_TOGGLE;
                            r_out.slot          <= r_slot;
                            r_out.choice        <= '0;
                            r_out.set_count     <= '0;
                            r_out.last          <= 1'b0;
                        end
                        if (r_slot == TL_LAST) begin
                            r_slot  <= '0;
                            r_state <= ST_SCAN;
                        end else begin
                            r_slot <= r_slot + 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    if (sel_applies && (radix != '0)) begin
                        r_radix   <= radix;
                        r_choices <= choices;
                        r_opt     <= opt;
                        r_step    <= '0;
                        r_state   <= ST_DIV;
                    end else if (r_slot == SL_LAST) begin
                        r_state <= ST_FINAL;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!emit_pair || out_free) begin
                        if (emit_pair) begin
                            r_out_valid     <= 1'b1;
                            r_out.item_kind <= osmrd_pkg::KIND_SELECT;
                            r_out.slot      <= r_slot;
                            r_out.choice    <= digit;
                            r_out.set_count <= '0;
                            r_out.last      <= 1'b0;
                        end
                        if (r_slot == SL_LAST) begin
                            r_state <= ST_FINAL;
                        end else begin
                            r_slot  <= r_slot + 1'b1;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_FINAL: begin
                    if (out_free) begin
                        r_out_valid     <= 1'b1;
                        r_out.item_kind <= osmrd_pkg::KIND_FINAL;
                        r_out.slot      <= '0;
                        r_out.choice    <= '0;
                        r_out.set_count <= count;
                        r_out.last      <= 1'b1;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.last) |-> (o_out_item.item_kind == osmrd_pkg::KIND_FINAL))
        else $error("last flag on an item that is not the final count");

    a_count_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.item_kind != osmrd_pkg::KIND_FINAL))
            |-> ((o_out_item.set_count == '0) && !o_out_item.last))
        else $error("count or last set on a toggle or select item");

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_TOGGLE))
        else $error("accepted item did not start the toggle scan");

    a_div_ends_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && (r_step == STEP_LAST)) |=> (r_state == ST_EMIT))
        else $error("serial pass did not end in the emit step");

endmodule

>>> tb/sv/tb_option_set_mixed_radix_decode.sv
`timescale 1ns / 100ps
// testbench for option_set_mixed_radix_decode: a directed table, then random config phases
// each result is checked against an in-bench mixed-radix decoder or, for typed rows, a typed final count
// depends on osmrd_pkg and the block's rtl
module tb_option_set_mixed_radix_decode;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind                          kind;
        logic [osmrd_pkg::CFG_INDEX_W-1:0]  reg_index;
        logic [osmrd_pkg::CFG_DATA_W-1:0]   reg_value;
        osmrd_pkg::t_in_item                item;
        logic                               typed;
        logic [osmrd_pkg::COUNT_W-1:0]      typed_count;
    } t_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [osmrd_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [osmrd_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    osmrd_pkg::t_in_item               i_in_item = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    osmrd_pkg::t_out_item              o_out_item;

    logic [osmrd_pkg::TOGGLE_REG_W-1:0] tog_vertex = '0;
    logic [osmrd_pkg::TOGGLE_REG_W-1:0] tog_pixel = '0;
    logic [osmrd_pkg::SELECT_REG_W-1:0] sel_vertex = '0;
    logic [osmrd_pkg::SELECT_REG_W-1:0] sel_pixel = '0;
    logic [osmrd_pkg::CFG_DATA_W-1:0]   choice_counts = '0;
    logic [osmrd_pkg::SELECT_REG_W-1:0] optional_mask = '0;

    osmrd_pkg::t_out_item pending_results[$];
    t_row                 stim_table[$];
    int                   n_errors = 0;
    int                   next_gap = 0;
    bit                   sender_lazy = 1'b1;
    bit                   receiver_lazy = 1'b1;

    option_set_mixed_radix_decode DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    function automatic int draw_wait(bit lazy);
        return lazy ? int'($urandom_range(0, 9)) : 0;
    endfunction

    function automatic void decode_option_index(osmrd_pkg::t_in_item it);
        logic [osmrd_pkg::TOGGLE_REG_W-1:0] tmask;
        logic [osmrd_pkg::SELECT_REG_W-1:0] smask;
        logic [63:0]                        idx;
        logic [63:0]                        count;
        logic [63:0]                        radix;
        logic [63:0]                        digit;
        logic [osmrd_pkg::CHOICE_W-1:0]     choices;
        logic                               opt;
        osmrd_pkg::t_out_item               r;
        idx = 64'(it.option_index);
        count = 64'd1;
        tmask = it.shader_type ? tog_pixel : tog_vertex;
        smask = it.shader_type ? sel_pixel : sel_vertex;
        for (int t = 0; t < osmrd_pkg::TOGGLE_REG_W; t++) begin
            if (tmask[t]) begin
                if (idx[0]) begin
                    r = '0;
                    r.item_kind = osmrd_pkg::KIND_TOGGLE;
                    r.slot = osmrd_pkg::SLOT_W'(t);
                    pending_results.push_back(r);
                end
                idx = idx >> 1;
                count = count << 1;
            end
        end
        for (int s = 0; s < osmrd_pkg::SELECT_REG_W; s++) begin
            if (smask[s]) begin
                choices = choice_counts[osmrd_pkg::CHOICE_W*s +: osmrd_pkg::CHOICE_W];
                opt = optional_mask[s];
                radix = 64'(choices) + 64'(opt);
                count = count * radix;
                if (radix != 0) begin
                    digit = idx % radix;
                    idx = idx / radix;
                    if (!opt || digit != 64'(choices)) begin
                        r = '0;
                        r.item_kind = osmrd_pkg::KIND_SELECT;
                        r.slot = osmrd_pkg::SLOT_W'(s);
                        r.choice = osmrd_pkg::CHOICE_W'(digit);
                        pending_results.push_back(r);
                    end
                end
            end
        end
        r = '0;
        r.item_kind = osmrd_pkg::KIND_FINAL;
        r.set_count = osmrd_pkg::COUNT_W'(count);
        r.last = 1'b1;
        pending_results.push_back(r);
    endfunction

    function automatic logic [osmrd_pkg::IN_INDEX_W-1:0] rand_index();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return osmrd_pkg::IN_INDEX_W'($urandom_range(0, 255));
            2: return '0;
            default: return osmrd_pkg::IN_INDEX_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [osmrd_pkg::CFG_DATA_W-1:0] rand_reg(int phase,
            logic [osmrd_pkg::CFG_DATA_W-1:0] full);
        if (phase == 0) return full;
        if (phase == 1) return '0;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return full;
            default: return $urandom & full;
        endcase
    endfunction

    function automatic void add_cfg(logic [osmrd_pkg::CFG_INDEX_W-1:0] idx,
                                    logic [osmrd_pkg::CFG_DATA_W-1:0] val);
        t_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_index = idx;
        row.reg_value = val;
        stim_table.push_back(row);
    endfunction

    function automatic void add_item(logic shader, logic [osmrd_pkg::IN_INDEX_W-1:0] idx,
                                     logic typed, logic [osmrd_pkg::COUNT_W-1:0] count);
        t_row row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item.shader_type = shader;
        row.item.option_index = idx;
        row.typed = typed;
        row.typed_count = count;
        stim_table.push_back(row);
    endfunction

    task automatic write_reg(logic [osmrd_pkg::CFG_INDEX_W-1:0] idx,
                             logic [osmrd_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            osmrd_pkg::CFG_TOGGLE_VERTEX: tog_vertex = val[osmrd_pkg::TOGGLE_REG_W-1:0];
            osmrd_pkg::CFG_TOGGLE_PIXEL:  tog_pixel = val[osmrd_pkg::TOGGLE_REG_W-1:0];
            osmrd_pkg::CFG_SELECT_VERTEX: sel_vertex = val[osmrd_pkg::SELECT_REG_W-1:0];
            osmrd_pkg::CFG_SELECT_PIXEL:  sel_pixel = val[osmrd_pkg::SELECT_REG_W-1:0];
            osmrd_pkg::CFG_CHOICE_COUNTS: choice_counts = val;
            osmrd_pkg::CFG_OPTIONAL:      optional_mask = val[osmrd_pkg::SELECT_REG_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_item(osmrd_pkg::t_in_item it, bit more);
        repeat (next_gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        next_gap = draw_wait(sender_lazy);
        if (!more || next_gap != 0) begin
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic check_result(osmrd_pkg::t_out_item got);
        osmrd_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            $display("%0t unexpected result: kind %0d slot %0d choice %0d count %0d last %0d",
                     $time, got.item_kind, got.slot, got.choice, got.set_count, got.last);
            n_errors++;
        end else begin
            want = pending_results.pop_front();
            if (got.item_kind !== want.item_kind) begin
                $display("%0t item_kind expected %0d got %0d", $time, want.item_kind,
                         got.item_kind);
                n_errors++;
            end
            if (got.slot !== want.slot) begin
                $display("%0t slot expected %0d got %0d", $time, want.slot, got.slot);
                n_errors++;
            end
            if (got.choice !== want.choice) begin
                $display("%0t choice expected %0d got %0d", $time, want.choice, got.choice);
                n_errors++;
            end
            if (got.set_count !== want.set_count) begin
                $display("%0t set_count expected %0d got %0d", $time, want.set_count,
                         got.set_count);
                n_errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t last expected %0d got %0d", $time, want.last, got.last);
                n_errors++;
            end
        end
    endtask

    // result side: random stall before each item when the receiver is lazy
    initial begin
        int hold;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = draw_wait(receiver_lazy);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            check_result(o_out_item);
        end
    end

    initial begin
        #20_000_000;
        $display("tb_option_set_mixed_radix_decode failed");
        $finish;
    end

    initial begin
        t_row                 row;
        osmrd_pkg::t_in_item  it;
        osmrd_pkg::t_out_item fin;
        bit                   cfg_open;
        cfg_open = 1'b0;

        // after reset nothing applies, the count is one
        add_item(1'b0, 48'd0, 1'b1, 49'd1);
        add_item(1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, 49'd1);
        add_cfg(osmrd_pkg::CFG_TOGGLE_VERTEX, 32'h0000_FFFF);
        add_cfg(osmrd_pkg::CFG_TOGGLE_PIXEL, 32'h0000_8001);
        add_item(1'b0, 48'h0000_0000_FFFF, 1'b0, '0);
        add_item(1'b1, 48'h0000_0000_0003, 1'b0, '0);
        add_item(1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, '0);
        add_cfg(osmrd_pkg::CFG_SELECT_VERTEX, 32'h0000_00FF);
        add_cfg(osmrd_pkg::CFG_SELECT_PIXEL, 32'h0000_0081);
        add_cfg(osmrd_pkg::CFG_CHOICE_COUNTS, 32'hFFFF_FFFF);
        add_cfg(osmrd_pkg::CFG_OPTIONAL, 32'h0000_0000);
        add_item(1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, '0);
        add_item(1'b0, 48'd0, 1'b0, '0);
        add_item(1'b1, 48'd123456789, 1'b0, '0);
        // every select optional: count reaches two to the 48
        add_cfg(osmrd_pkg::CFG_OPTIONAL, 32'h0000_00FF);
        add_item(1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, '0);
        add_item(1'b0, 48'h0123_4567_89AB, 1'b0, '0);
        // zero radix select
        add_cfg(osmrd_pkg::CFG_TOGGLE_VERTEX, 32'h0000_0000);
        add_cfg(osmrd_pkg::CFG_SELECT_VERTEX, 32'h0000_0001);
        add_cfg(osmrd_pkg::CFG_CHOICE_COUNTS, 32'h0000_0000);
        add_cfg(osmrd_pkg::CFG_OPTIONAL, 32'h0000_0000);
        add_item(1'b0, 48'd5, 1'b1, 49'd0);
        // optional select absent
        add_cfg(osmrd_pkg::CFG_CHOICE_COUNTS, 32'h0000_0003);
        add_cfg(osmrd_pkg::CFG_OPTIONAL, 32'h0000_0001);
        add_item(1'b0, 48'd3, 1'b1, 49'd4);
        add_item(1'b0, 48'd2, 1'b0, '0);
        add_cfg(osmrd_pkg::CFG_TOGGLE_PIXEL, 32'h0000_00F0);
        add_cfg(osmrd_pkg::CFG_SELECT_PIXEL, 32'h0000_00FF);
        add_cfg(osmrd_pkg::CFG_CHOICE_COUNTS, 32'h0F30_5A21);
        add_cfg(osmrd_pkg::CFG_OPTIONAL, 32'h0000_005A);
        add_item(1'b1, 48'hFFFF_FFFF_FFFF, 1'b0, '0);
        add_item(1'b1, 48'd12345, 1'b0, '0);
        add_item(1'b1, 48'h0000_0000_00F0, 1'b0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < stim_table.size(); k++) begin
            row = stim_table[k];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_reg(row.reg_index, row.reg_value);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_item(row.item, k + 1 < stim_table.size() &&
                                    stim_table[k + 1].kind == ROW_ITEM);
                if (row.typed) begin
                    fin = '0;
                    fin.item_kind = osmrd_pkg::KIND_FINAL;
                    fin.set_count = row.typed_count;
                    fin.last = 1'b1;
                    pending_results.push_back(fin);
                end else begin
                    decode_option_index(row.item);
                end
            end
        end
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            sender_lazy = (p == 0) || ($urandom_range(0, 3) != 0);
            receiver_lazy = (p == 1) || ($urandom_range(0, 3) != 0);
            write_reg(osmrd_pkg::CFG_TOGGLE_VERTEX, rand_reg(p, 32'h0000_FFFF));
            write_reg(osmrd_pkg::CFG_TOGGLE_PIXEL, rand_reg(p, 32'h0000_FFFF));
            write_reg(osmrd_pkg::CFG_SELECT_VERTEX, rand_reg(p, 32'h0000_00FF));
            write_reg(osmrd_pkg::CFG_SELECT_PIXEL, rand_reg(p, 32'h0000_00FF));
            write_reg(osmrd_pkg::CFG_CHOICE_COUNTS, rand_reg(p, 32'hFFFF_FFFF));
            write_reg(osmrd_pkg::CFG_OPTIONAL, rand_reg(p, 32'h0000_00FF));
            i_cfg_we <= 1'b0;
            for (int n = 0; n < 26; n++) begin
                it.shader_type = 1'($urandom_range(0, 1));
                it.option_index = rand_index();
                send_item(it, n != 12 && n != 25);
                decode_option_index(it);
                // hold off mid phase until the block has drained
                if (n == 12) wait_idle();
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("tb_option_set_mixed_radix_decode passed");
        end else begin
            $display("tb_option_set_mixed_radix_decode failed");
        end
        $finish;
    end

endmodule
